/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the ray and triangle tester.
// Depends on nothing; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTI_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTI_ASSERT(lbl, prop, msg)
`define RTI_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

/* rtl/rti_pkg.sv */
// Types, constants and fixed-point helpers of the ray and triangle tester.
// Used by every module in rtl but rti_delay; depends on nothing.
package rti_pkg;

  localparam int CW      = 32;
  localparam int FB      = 16;
  localparam int PW      = 2 * CW - FB;
  localparam int SW      = PW + 2;
  localparam int TW      = 16;
  localparam int DIV_LAT = CW + 2;

  localparam logic [CW-1:0] ONE_Q   = CW'(1) << FB;
  localparam logic [TW-1:0] TOL_RST = TW'(655);

  typedef logic signed [CW-1:0] fix_t;
  typedef logic signed [PW-1:0] raw_t;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_PARA  = 2'd2,
    ST_DEGEN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_ORG_X  = 3'd0,
    CFG_ORG_Y  = 3'd1,
    CFG_ORG_Z  = 3'd2,
    CFG_DIR_X  = 3'd3,
    CFG_DIR_Y  = 3'd4,
    CFG_DIR_Z  = 3'd5,
    CFG_COMP_N = 3'd6,
    CFG_TOL    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
  } vec_t;

  typedef struct packed {
    vec_t            org;
    vec_t            dir;
    logic            comp_n;
    logic [TW-1:0]   tol;
  } ray_cfg_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
    vec_t gn;
  } tri_t;

  typedef struct packed {
    logic degen;
    logic para;
  } flags_t;

  typedef struct packed {
    vec_t   a;
    vec_t   e1;
    vec_t   e2;
    fix_t   a00;
    fix_t   a01;
    fix_t   a11;
    fix_t   det;
    flags_t flg;
  } lam_side_t;

  typedef struct packed {
    vec_t   q;
    flags_t flg;
  } rs_side_t;

  // Full product, shifted down with rounding toward minus infinity.
  function automatic raw_t mul_fl(input fix_t a, input fix_t b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    return p[2*CW-1:FB];
  endfunction

  function automatic fix_t sat_w(input logic signed [SW-1:0] x);
    fix_t r;
    if ((&x[SW-1:CW-1]) || !(|x[SW-1:CW-1])) begin
      r = x[CW-1:0];
    end else if (x[SW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic fix_t fadd(input fix_t a, input fix_t b);
    return sat_w(SW'(a) + SW'(b));
  endfunction

  function automatic fix_t fsub(input fix_t a, input fix_t b);
    return sat_w(SW'(a) - SW'(b));
  endfunction

  function automatic fix_t sum3(input raw_t a, input raw_t b, input raw_t c);
    return sat_w(SW'(a) + SW'(b) + SW'(c));
  endfunction

  function automatic fix_t dif2(input raw_t a, input raw_t b);
    return sat_w(SW'(a) - SW'(b));
  endfunction

endpackage

/* rtl/ray_triangle_intersect_core.sv */
// Ray against triangle tester: one triangle per clock against a configured ray.
// Every start word is accepted (busy stays low) and its result appears as a
// one-cycle out_valid strobe; the receiver cannot stall, and results leave in
// the order the triangles arrived. The path runs through two 34-stage
// bit-per-stage dividers (ray parameter, then r and s side by side) plus eleven
// multiply and add stages and one output register. Configuration is taken at
// any cycle with cfg_ready high, but should change only when no triangle is in
// flight. Depends on rti_pkg, rti_geom, rti_div, rti_solve, rti_delay and
// assert_macros.svh.
`include "assert_macros.svh"
module ray_triangle_intersect_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  rti_pkg::fix_t          in_a_x,
  input  rti_pkg::fix_t          in_a_y,
  input  rti_pkg::fix_t          in_a_z,
  input  rti_pkg::fix_t          in_b_x,
  input  rti_pkg::fix_t          in_b_y,
  input  rti_pkg::fix_t          in_b_z,
  input  rti_pkg::fix_t          in_c_x,
  input  rti_pkg::fix_t          in_c_y,
  input  rti_pkg::fix_t          in_c_z,
  input  rti_pkg::fix_t          in_given_nx,
  input  rti_pkg::fix_t          in_given_ny,
  input  rti_pkg::fix_t          in_given_nz,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output rti_pkg::fix_t          out_hit_x,
  output rti_pkg::fix_t          out_hit_y,
  output rti_pkg::fix_t          out_hit_z,
  output rti_pkg::fix_t          out_coord_r,
  output rti_pkg::fix_t          out_coord_s,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [rti_pkg::CW-1:0] cfg_wdata
);
  import rti_pkg::*;

  localparam int LAT = 12 + 2 * DIV_LAT;

  ray_cfg_t  cfg_r, cfg_nxt;
  tri_t      tri_in;
  logic      g_vld, l_vld, s_vld, r_vld, s2_vld;
  lam_side_t g_side, l_side;
  fix_t      g_num, g_den, lam, nr, ns, det, coord_r, coord_s;
  rs_side_t  rs_side, rs_dly;

  logic                 out_valid_r;
  status_t              status_r, status_nxt;
  vec_t                 hit_r, hit_nxt;
  fix_t                 cr_r, cs_r, cr_nxt, cs_nxt;
  logic signed [CW+1:0] rr, ss, tt, one_ext;
  logic                 bounds_ok;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORG_X:  cfg_nxt.org.x  = cfg_wdata;
        CFG_ORG_Y:  cfg_nxt.org.y  = cfg_wdata;
        CFG_ORG_Z:  cfg_nxt.org.z  = cfg_wdata;
        CFG_DIR_X:  cfg_nxt.dir.x  = cfg_wdata;
        CFG_DIR_Y:  cfg_nxt.dir.y  = cfg_wdata;
        CFG_DIR_Z:  cfg_nxt.dir.z  = cfg_wdata;
        CFG_COMP_N: cfg_nxt.comp_n = cfg_wdata[0];
        CFG_TOL:    cfg_nxt.tol    = cfg_wdata[TW-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.org   <= '0;
      cfg_r.dir.x <= '0;
      cfg_r.dir.y <= '0;
      cfg_r.dir.z <= ONE_Q;
      cfg_r.comp_n <= 1'b1;
      cfg_r.tol   <= TOL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign tri_in.a  = '{x: in_a_x, y: in_a_y, z: in_a_z};
  assign tri_in.b  = '{x: in_b_x, y: in_b_y, z: in_b_z};
  assign tri_in.c  = '{x: in_c_x, y: in_c_y, z: in_c_z};
  assign tri_in.gn = '{x: in_given_nx, y: in_given_ny, z: in_given_nz};

  rti_geom u_geom (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start && !busy),
    .tri_in (tri_in),
    .cfg    (cfg_r),
    .out_vld(g_vld),
    .side   (g_side),
    .num    (g_num),
    .den    (g_den)
  );

  rti_div u_div_lam (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (g_vld),
    .num    (g_num),
    .den    (g_den),
    .out_vld(l_vld),
    .quo    (lam)
  );

  rti_delay #(.W($bits(lam_side_t)), .DEPTH(DIV_LAT)) u_dly_lam (
    .clk(clk),
    .d  (g_side),
    .q  (l_side)
  );

  rti_solve u_solve (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (l_vld),
    .side     (l_side),
    .lam      (lam),
    .cfg      (cfg_r),
    .out_vld  (s_vld),
    .rs       (rs_side),
    .num_r_out(nr),
    .num_s_out(ns),
    .det      (det)
  );

  rti_div u_div_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (s_vld),
    .num    (nr),
    .den    (det),
    .out_vld(r_vld),
    .quo    (coord_r)
  );

  rti_div u_div_s (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (s_vld),
    .num    (ns),
    .den    (det),
    .out_vld(s2_vld),
    .quo    (coord_s)
  );

  rti_delay #(.W($bits(rs_side_t)), .DEPTH(DIV_LAT)) u_dly_rs (
    .clk(clk),
    .d  (rs_side),
    .q  (rs_dly)
  );

  // Inside test in a width that holds r + s and the widened bounds.
  assign rr        = (CW+2)'(coord_r);
  assign ss        = (CW+2)'(coord_s);
  assign tt        = $signed({{(CW+2-TW){1'b0}}, cfg_r.tol});
  assign one_ext   = $signed({2'b00, ONE_Q});
  assign bounds_ok = (rr >= -tt) && (ss >= -tt) && ((rr + ss) <= (one_ext + tt));

  always_comb begin
    if (rs_dly.flg.degen) begin
      status_nxt = ST_DEGEN;
    end else if (rs_dly.flg.para) begin
      status_nxt = ST_PARA;
    end else if (bounds_ok) begin
      status_nxt = ST_HIT;
    end else begin
      status_nxt = ST_MISS;
    end
  end

  always_comb begin
    if (rs_dly.flg.degen || rs_dly.flg.para) begin
      hit_nxt = '0;
      cr_nxt  = '0;
      cs_nxt  = '0;
    end else begin
      hit_nxt = rs_dly.q;
      cr_nxt  = coord_r;
      cs_nxt  = coord_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= r_vld && s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
    cr_r     <= cr_nxt;
    cs_r     <= cs_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_hit_x   = hit_r.x;
  assign out_hit_y   = hit_r.y;
  assign out_hit_z   = hit_r.z;
  assign out_coord_r = cr_r;
  assign out_coord_s = cs_r;

  `RTI_ASSERT(a_lat, out_valid |-> $past(start, LAT), "result word without a start LAT cycles before")
  `RTI_ASSERT(a_div_sync, r_vld == s2_vld, "r and s dividers out of step")
  `RTI_ASSERT(a_zero, (out_valid && out_status != ST_HIT && out_status != ST_MISS) |-> (out_hit_x == '0 && out_coord_r == '0 && out_coord_s == '0), "nonzero fields on parallel or degenerate result")
  `RTI_ASSERT_NORST(a_rst, !rst_n |=> !out_valid, "result strobe right after reset")

endmodule

/* rtl/rti_delay.sv */
// Shift line that carries side data alongside a divider.
// Depends on nothing but its parameters.
module rti_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

/* rtl/rti_div.sv */
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating.
// Depends on rti_pkg.
module rti_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  rti_pkg::fix_t num,
  input  rti_pkg::fix_t den,
  output logic         out_vld,
  output rti_pkg::fix_t quo
);
  import rti_pkg::*;

  localparam int NS = CW;

  logic          vld_r [NS+1];
  logic [CW-1:0] rem_r [NS+1];
  logic [CW-1:0] dvs_r [NS+1];
  logic [CW-1:0] low_r [NS+1];
  logic [CW-1:0] q_r   [NS+1];
  logic          neg_r [NS+1];
  logic          ovf_r [NS+1];
  logic [CW-1:0] rem_nxt [NS+1];
  logic [CW-1:0] q_nxt   [NS+1];
  logic [CW-1:0] mag_n, mag_d;
  logic [CW:0]   sh;
  logic          out_vld_r;
  fix_t          quo_r, quo_nxt;

  assign mag_n = num[CW-1] ? (~num + CW'(1)) : num;
  assign mag_d = den[CW-1] ? (~den + CW'(1)) : den;

  // Restoring step: shift in the next dividend bit, subtract when it fits.
  always_comb begin
    rem_nxt[0] = '0;
    q_nxt[0]   = '0;
    for (int k = 1; k <= NS; k++) begin
      sh = {rem_r[k-1], low_r[k-1][CW-1]};
      if (sh >= {1'b0, dvs_r[k-1]}) begin
        rem_nxt[k] = CW'(sh - {1'b0, dvs_r[k-1]});
        q_nxt[k]   = {q_r[k-1][CW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[CW-1:0];
        q_nxt[k]   = {q_r[k-1][CW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (ovf_r[NS]) begin
      quo_nxt = neg_r[NS] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else if (neg_r[NS]) begin
      quo_nxt = (q_r[NS] > {1'b1, {(CW-1){1'b0}}}) ? {1'b1, {(CW-1){1'b0}}}
                                                   : fix_t'(~q_r[NS] + CW'(1));
    end else begin
      quo_nxt = (q_r[NS] > {1'b0, {(CW-1){1'b1}}}) ? {1'b0, {(CW-1){1'b1}}}
                                                   : fix_t'(q_r[NS]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k <= NS; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_vld_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= mag_n >> FB;
    low_r[0] <= mag_n << (CW - FB);
    dvs_r[0] <= mag_d;
    q_r[0]   <= q_nxt[0] | rem_nxt[0];
    neg_r[0] <= num[CW-1] ^ den[CW-1];
    // The quotient needs more than CW bits exactly when |n| >= |d| * 2^FB.
    ovf_r[0] <= ({{FB{1'b0}}, mag_n} >= {mag_d, {FB{1'b0}}});
    for (int k = 1; k <= NS; k++) begin
      rem_r[k] <= rem_nxt[k];
      low_r[k] <= {low_r[k-1][CW-2:0], 1'b0};
      dvs_r[k] <= dvs_r[k-1];
      q_r[k]   <= q_nxt[k];
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
    quo_r <= quo_nxt;
  end

  assign out_vld = out_vld_r;
  assign quo     = quo_r;

endmodule

/* rtl/rti_geom.sv */
// Front half: edges, Gram matrix, face normal (computed or supplied), determinant,
// plane dot products. Five register stages; depends on rti_pkg.
module rti_geom (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  rti_pkg::tri_t       tri_in,
  input  rti_pkg::ray_cfg_t   cfg,
  output logic                out_vld,
  output rti_pkg::lam_side_t  side,
  output rti_pkg::fix_t       num,
  output rti_pkg::fix_t       den
);
  import rti_pkg::*;

  logic vld_r [5];

  // Stage 1
  vec_t a1_r, e11_r, e21_r, w1_r, gn1_r;
  // Stage 2
  vec_t a2_r, e12_r, e22_r, w2_r, gn2_r;
  raw_t p11_r [3];
  raw_t p12_r [3];
  raw_t p22_r [3];
  raw_t cr_r  [6];
  // Stage 3
  vec_t a3_r, e13_r, e23_r, w3_r, fn3_r;
  fix_t a00_3_r, a01_3_r, a11_3_r;
  // Stage 4
  vec_t a4_r, e14_r, e24_r;
  fix_t a00_4_r, a01_4_r, a11_4_r;
  raw_t m0_r, m1_r;
  raw_t dd_r [3];
  raw_t nn_r [3];
  // Stage 5
  lam_side_t side_r;
  fix_t      num_r, den_r;
  fix_t      det_nxt, den_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < 5; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign det_nxt = dif2(m0_r, m1_r);
  assign den_nxt = sum3(dd_r[0], dd_r[1], dd_r[2]);

  always_ff @(posedge clk) begin
    a1_r    <= tri_in.a;
    gn1_r   <= tri_in.gn;
    e11_r.x <= fsub(tri_in.b.x, tri_in.a.x);
    e11_r.y <= fsub(tri_in.b.y, tri_in.a.y);
    e11_r.z <= fsub(tri_in.b.z, tri_in.a.z);
    e21_r.x <= fsub(tri_in.c.x, tri_in.a.x);
    e21_r.y <= fsub(tri_in.c.y, tri_in.a.y);
    e21_r.z <= fsub(tri_in.c.z, tri_in.a.z);
    w1_r.x  <= fsub(tri_in.a.x, cfg.org.x);
    w1_r.y  <= fsub(tri_in.a.y, cfg.org.y);
    w1_r.z  <= fsub(tri_in.a.z, cfg.org.z);

    a2_r  <= a1_r;
    e12_r <= e11_r;
    e22_r <= e21_r;
    w2_r  <= w1_r;
    gn2_r <= gn1_r;
    p11_r[0] <= mul_fl(e11_r.x, e11_r.x);
    p11_r[1] <= mul_fl(e11_r.y, e11_r.y);
    p11_r[2] <= mul_fl(e11_r.z, e11_r.z);
    p12_r[0] <= mul_fl(e11_r.x, e21_r.x);
    p12_r[1] <= mul_fl(e11_r.y, e21_r.y);
    p12_r[2] <= mul_fl(e11_r.z, e21_r.z);
    p22_r[0] <= mul_fl(e21_r.x, e21_r.x);
    p22_r[1] <= mul_fl(e21_r.y, e21_r.y);
    p22_r[2] <= mul_fl(e21_r.z, e21_r.z);
    cr_r[0]  <= mul_fl(e11_r.y, e21_r.z);
    cr_r[1]  <= mul_fl(e11_r.z, e21_r.y);
    cr_r[2]  <= mul_fl(e11_r.z, e21_r.x);
    cr_r[3]  <= mul_fl(e11_r.x, e21_r.z);
    cr_r[4]  <= mul_fl(e11_r.x, e21_r.y);
    cr_r[5]  <= mul_fl(e11_r.y, e21_r.x);

    a3_r    <= a2_r;
    e13_r   <= e12_r;
    e23_r   <= e22_r;
    w3_r    <= w2_r;
    a00_3_r <= sum3(p11_r[0], p11_r[1], p11_r[2]);
    a01_3_r <= sum3(p12_r[0], p12_r[1], p12_r[2]);
    a11_3_r <= sum3(p22_r[0], p22_r[1], p22_r[2]);
    if (cfg.comp_n) begin
      fn3_r.x <= dif2(cr_r[0], cr_r[1]);
      fn3_r.y <= dif2(cr_r[2], cr_r[3]);
      fn3_r.z <= dif2(cr_r[4], cr_r[5]);
    end else begin
      fn3_r <= gn2_r;
    end

    a4_r    <= a3_r;
    e14_r   <= e13_r;
    e24_r   <= e23_r;
    a00_4_r <= a00_3_r;
    a01_4_r <= a01_3_r;
    a11_4_r <= a11_3_r;
    m0_r    <= mul_fl(a00_3_r, a11_3_r);
    m1_r    <= mul_fl(a01_3_r, a01_3_r);
    dd_r[0] <= mul_fl(fn3_r.x, cfg.dir.x);
    dd_r[1] <= mul_fl(fn3_r.y, cfg.dir.y);
    dd_r[2] <= mul_fl(fn3_r.z, cfg.dir.z);
    nn_r[0] <= mul_fl(fn3_r.x, w3_r.x);
    nn_r[1] <= mul_fl(fn3_r.y, w3_r.y);
    nn_r[2] <= mul_fl(fn3_r.z, w3_r.z);

    side_r.a         <= a4_r;
    side_r.e1        <= e14_r;
    side_r.e2        <= e24_r;
    side_r.a00       <= a00_4_r;
    side_r.a01       <= a01_4_r;
    side_r.a11       <= a11_4_r;
    side_r.det       <= det_nxt;
    side_r.flg.degen <= (det_nxt == '0);
    side_r.flg.para  <= (den_nxt == '0);
    den_r            <= den_nxt;
    num_r            <= sum3(nn_r[0], nn_r[1], nn_r[2]);
  end

  assign out_vld = vld_r[4];
  assign side    = side_r;
  assign num     = num_r;
  assign den     = den_r;

endmodule

/* rtl/rti_solve.sv */
// Back half: hit point from the ray parameter, then the numerators of r and s.
// Six register stages; depends on rti_pkg.
module rti_solve (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  rti_pkg::lam_side_t  side,
  input  rti_pkg::fix_t       lam,
  input  rti_pkg::ray_cfg_t   cfg,
  output logic                out_vld,
  output rti_pkg::rs_side_t   rs,
  output rti_pkg::fix_t       num_r_out,
  output rti_pkg::fix_t       num_s_out,
  output rti_pkg::fix_t       det
);
  import rti_pkg::*;

  logic vld_r [6];

  lam_side_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r;
  raw_t      dq_r [3];
  vec_t      q2_r, p2_r, q3_r, q4_r, q5_r, q6_r;
  fix_t      q2x_nxt, q2y_nxt, q2z_nxt;
  raw_t      pa_r [3];
  raw_t      pb_r [3];
  fix_t      pe1_r, pe2_r;
  raw_t      ma_r, mb_r, mc_r, md_r;
  fix_t      nr_r, ns_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < 6; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign q2x_nxt = fadd(cfg.org.x, sat_w(SW'(dq_r[0])));
  assign q2y_nxt = fadd(cfg.org.y, sat_w(SW'(dq_r[1])));
  assign q2z_nxt = fadd(cfg.org.z, sat_w(SW'(dq_r[2])));

  always_ff @(posedge clk) begin
    s1_r    <= side;
    dq_r[0] <= mul_fl(cfg.dir.x, lam);
    dq_r[1] <= mul_fl(cfg.dir.y, lam);
    dq_r[2] <= mul_fl(cfg.dir.z, lam);

    s2_r   <= s1_r;
    q2_r.x <= q2x_nxt;
    q2_r.y <= q2y_nxt;
    q2_r.z <= q2z_nxt;
    p2_r.x <= fsub(q2x_nxt, s1_r.a.x);
    p2_r.y <= fsub(q2y_nxt, s1_r.a.y);
    p2_r.z <= fsub(q2z_nxt, s1_r.a.z);

    s3_r    <= s2_r;
    q3_r    <= q2_r;
    pa_r[0] <= mul_fl(p2_r.x, s2_r.e1.x);
    pa_r[1] <= mul_fl(p2_r.y, s2_r.e1.y);
    pa_r[2] <= mul_fl(p2_r.z, s2_r.e1.z);
    pb_r[0] <= mul_fl(p2_r.x, s2_r.e2.x);
    pb_r[1] <= mul_fl(p2_r.y, s2_r.e2.y);
    pb_r[2] <= mul_fl(p2_r.z, s2_r.e2.z);

    s4_r  <= s3_r;
    q4_r  <= q3_r;
    pe1_r <= sum3(pa_r[0], pa_r[1], pa_r[2]);
    pe2_r <= sum3(pb_r[0], pb_r[1], pb_r[2]);

    s5_r <= s4_r;
    q5_r <= q4_r;
    ma_r <= mul_fl(s4_r.a11, pe1_r);
    mb_r <= mul_fl(s4_r.a01, pe2_r);
    mc_r <= mul_fl(s4_r.a00, pe2_r);
    md_r <= mul_fl(s4_r.a01, pe1_r);

    s6_r <= s5_r;
    q6_r <= q5_r;
    nr_r <= dif2(ma_r, mb_r);
    ns_r <= dif2(mc_r, md_r);
  end

  assign out_vld   = vld_r[5];
  assign rs.q      = q6_r;
  assign rs.flg    = s6_r.flg;
  assign num_r_out = nr_r;
  assign num_s_out = ns_r;
  assign det       = s6_r.det;

endmodule

/* sim/ray_triangle_checker.sv */
// Checker for the ray and triangle tester: watches the triangle, result and
// register channels, predicts each result and compares it. Depends on rti_pkg.
`timescale 1ns / 1ps
module ray_triangle_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  rti_pkg::fix_t          in_a_x,
  input  rti_pkg::fix_t          in_a_y,
  input  rti_pkg::fix_t          in_a_z,
  input  rti_pkg::fix_t          in_b_x,
  input  rti_pkg::fix_t          in_b_y,
  input  rti_pkg::fix_t          in_b_z,
  input  rti_pkg::fix_t          in_c_x,
  input  rti_pkg::fix_t          in_c_y,
  input  rti_pkg::fix_t          in_c_z,
  input  rti_pkg::fix_t          in_given_nx,
  input  rti_pkg::fix_t          in_given_ny,
  input  rti_pkg::fix_t          in_given_nz,
  input  logic                   out_valid,
  input  logic [1:0]             out_status,
  input  rti_pkg::fix_t          out_hit_x,
  input  rti_pkg::fix_t          out_hit_y,
  input  rti_pkg::fix_t          out_hit_z,
  input  rti_pkg::fix_t          out_coord_r,
  input  rti_pkg::fix_t          out_coord_s,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [rti_pkg::CW-1:0] cfg_wdata,
  output int                     errors,
  output int                     pending
);
  import rti_pkg::*;

  typedef struct {
    status_t st;
    fix_t    hx;
    fix_t    hy;
    fix_t    hz;
    fix_t    r;
    fix_t    s;
  } hit_word_t;

  hit_word_t hit_queue[$];

  longint org[3];
  longint dir[3];
  logic   comp_n;
  longint tol;

  function automatic longint clip(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Arithmetic shift of the full product floors toward minus infinity.
  function automatic longint prod(input longint a, input longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic longint dot3(input longint u[3], input longint v[3]);
    return clip(prod(u[0], v[0]) + prod(u[1], v[1]) + prod(u[2], v[2]));
  endfunction

  function automatic longint quot(input longint n, input longint d);
    if (d == 0) return 0;
    return clip((n * 65536) / d);
  endfunction

  function automatic hit_word_t predict(input longint a[3], input longint b[3],
                                        input longint c[3], input longint gn[3]);
    hit_word_t w;
    longint e1[3], e2[3], fn[3], wv[3], q[3], p[3];
    longint a00, a01, a11, det, den, num, lam, pe1, pe2, r, s;
    w = '{ST_DEGEN, 0, 0, 0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      e1[i] = clip(b[i] - a[i]);
      e2[i] = clip(c[i] - a[i]);
    end
    a00 = dot3(e1, e1);
    a01 = dot3(e1, e2);
    a11 = dot3(e2, e2);
    det = clip(prod(a00, a11) - prod(a01, a01));
    if (det == 0) return w;
    if (comp_n) begin
      fn[0] = clip(prod(e1[1], e2[2]) - prod(e1[2], e2[1]));
      fn[1] = clip(prod(e1[2], e2[0]) - prod(e1[0], e2[2]));
      fn[2] = clip(prod(e1[0], e2[1]) - prod(e1[1], e2[0]));
    end else begin
      fn = gn;
    end
    den = dot3(fn, dir);
    if (den == 0) begin
      w.st = ST_PARA;
      return w;
    end
    for (int i = 0; i < 3; i++) wv[i] = clip(a[i] - org[i]);
    num = dot3(fn, wv);
    lam = quot(num, den);
    for (int i = 0; i < 3; i++) begin
      q[i] = clip(org[i] + clip(prod(dir[i], lam)));
      p[i] = clip(q[i] - a[i]);
    end
    pe1 = dot3(p, e1);
    pe2 = dot3(p, e2);
    r = quot(clip(prod(a11, pe1) - prod(a01, pe2)), det);
    s = quot(clip(prod(a00, pe2) - prod(a01, pe1)), det);
    w.st = (r >= -tol && s >= -tol && r + s <= 65536 + tol) ? ST_HIT : ST_MISS;
    w.hx = fix_t'(q[0]);
    w.hy = fix_t'(q[1]);
    w.hz = fix_t'(q[2]);
    w.r  = fix_t'(r);
    w.s  = fix_t'(s);
    return w;
  endfunction

  always @(posedge clk) begin
    longint va[3], vb[3], vc[3], vg[3];
    hit_word_t want;
    if (!rst_n) begin
      org    = '{0, 0, 0};
      dir    = '{0, 0, 65536};
      comp_n = 1'b1;
      tol    = TOL_RST;
      errors = 0;
      hit_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ORG_X:  org[0] = fix_t'(cfg_wdata);
          CFG_ORG_Y:  org[1] = fix_t'(cfg_wdata);
          CFG_ORG_Z:  org[2] = fix_t'(cfg_wdata);
          CFG_DIR_X:  dir[0] = fix_t'(cfg_wdata);
          CFG_DIR_Y:  dir[1] = fix_t'(cfg_wdata);
          CFG_DIR_Z:  dir[2] = fix_t'(cfg_wdata);
          CFG_COMP_N: comp_n = cfg_wdata[0];
          CFG_TOL:    tol = longint'(cfg_wdata[TW-1:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        va = '{in_a_x, in_a_y, in_a_z};
        vb = '{in_b_x, in_b_y, in_b_z};
        vc = '{in_c_x, in_c_y, in_c_z};
        vg = '{in_given_nx, in_given_ny, in_given_nz};
        hit_queue.push_back(predict(va, vb, vc, vg));
      end
      if (out_valid) begin
        if (hit_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word, status %0d", out_status);
        end else begin
          want = hit_queue.pop_front();
          if (out_status !== want.st || out_hit_x !== want.hx || out_hit_y !== want.hy ||
              out_hit_z !== want.hz || out_coord_r !== want.r || out_coord_s !== want.s) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected st %0d hit %0d %0d %0d rs %0d %0d",
                       want.st, want.hx, want.hy, want.hz, want.r, want.s);
              $display("          actual   st %0d hit %0d %0d %0d rs %0d %0d",
                       out_status, out_hit_x, out_hit_y, out_hit_z,
                       out_coord_r, out_coord_s);
            end
          end
        end
      end
    end
    pending = hit_queue.size();
  end
endmodule

/* sim/testbench.sv */
// Top of the ray and triangle tester's testbench: clock, reset, triangle and
// register stimulus, verdict. Depends on rti_pkg and ray_triangle_checker.
`timescale 1ns / 1ps
module testbench;
  import rti_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tri_t tri_in = '0;
  logic out_valid;
  logic [1:0] out_status;
  fix_t out_hit_x, out_hit_y, out_hit_z, out_coord_r, out_coord_s;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;
  int errors, pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ray_triangle_intersect_core DUT (
    .clk, .rst_n, .start, .busy,
    .in_a_x(tri_in.a.x), .in_a_y(tri_in.a.y), .in_a_z(tri_in.a.z),
    .in_b_x(tri_in.b.x), .in_b_y(tri_in.b.y), .in_b_z(tri_in.b.z),
    .in_c_x(tri_in.c.x), .in_c_y(tri_in.c.y), .in_c_z(tri_in.c.z),
    .in_given_nx(tri_in.gn.x), .in_given_ny(tri_in.gn.y), .in_given_nz(tri_in.gn.z),
    .out_valid, .out_status, .out_hit_x, .out_hit_y, .out_hit_z,
    .out_coord_r, .out_coord_s,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  ray_triangle_checker u_checker (
    .clk, .rst_n, .start, .busy,
    .in_a_x(tri_in.a.x), .in_a_y(tri_in.a.y), .in_a_z(tri_in.a.z),
    .in_b_x(tri_in.b.x), .in_b_y(tri_in.b.y), .in_b_z(tri_in.b.z),
    .in_c_x(tri_in.c.x), .in_c_y(tri_in.c.y), .in_c_z(tri_in.c.z),
    .in_given_nx(tri_in.gn.x), .in_given_ny(tri_in.gn.y), .in_given_nz(tri_in.gn.z),
    .out_valid, .out_status, .out_hit_x, .out_hit_y, .out_hit_z,
    .out_coord_r, .out_coord_s,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata,
    .errors, .pending
  );

  function automatic fix_t near(input int span);
    return fix_t'($urandom_range(0, 2 * span)) - fix_t'(span);
  endfunction

  function automatic vec_t near_vec(input int span);
    return '{near(span), near(span), near(span)};
  endfunction

  function automatic vec_t wild_vec();
    return '{fix_t'($urandom), fix_t'($urandom), fix_t'($urandom)};
  endfunction

  // Drive one triangle word; it is taken at the edge where busy is low.
  task automatic send_tri(input tri_t t);
    @(negedge clk);
    tri_in = t;
    start  = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic rest(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Let every triangle in flight come out before the ray changes.
  task automatic drain();
    rest(1);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CW-1:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_ray(input vec_t o, input vec_t d, input logic cn,
                         input logic [TW-1:0] tl);
    write_reg(CFG_ORG_X, o.x);
    write_reg(CFG_ORG_Y, o.y);
    write_reg(CFG_ORG_Z, o.z);
    write_reg(CFG_DIR_X, d.x);
    write_reg(CFG_DIR_Y, d.y);
    write_reg(CFG_DIR_Z, d.z);
    write_reg(CFG_COMP_N, {31'd0, cn});
    write_reg(CFG_TOL, {16'd0, tl});
  endtask

  function automatic tri_t random_tri();
    tri_t t;
    int k;
    k = $urandom_range(0, 99);
    t.gn = near_vec(4 << FB);
    if (k < 70) begin
      // Small triangle around the ray's path, so hits and near misses are common.
      t.a = near_vec(3 << FB);
      t.b = near_vec(3 << FB);
      t.c = near_vec(3 << FB);
    end else if (k < 78) begin
      t.a = near_vec(3 << FB);
      t.b = t.a;
      t.c = near_vec(3 << FB);
    end else if (k < 84) begin
      t.a = near_vec(2 << FB);
      t.b = t.a;
      t.c = t.a;
      t.b.x = t.a.x + fix_t'(1 << FB);
      t.c.x = t.a.x + fix_t'(2 << FB);
    end else if (k < 90) begin
      t.a = near_vec(3 << FB);
      t.b = near_vec(3 << FB);
      t.c = near_vec(3 << FB);
      t.gn = '0;
    end else begin
      t.a = wild_vec();
      t.b = wild_vec();
      t.c = wild_vec();
      t.gn = wild_vec();
    end
    return t;
  endfunction

  localparam fix_t MAXV = 32'sh7fffffff;
  localparam fix_t MINV = 32'sh80000000;
  localparam fix_t ONE  = 32'sh00010000;

  initial begin
    tri_t t;
    int burst;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed words against the reset ray along +z from the origin.
    send_tri('{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, 0}});
    send_tri('{'{5 * ONE, 5 * ONE, ONE}, '{6 * ONE, 5 * ONE, ONE},
               '{5 * ONE, 6 * ONE, ONE}, '{0, 0, 0}});
    send_tri('{'{ONE, ONE, ONE}, '{ONE, ONE, ONE}, '{ONE, ONE, ONE}, '{0, 0, 0}});
    send_tri('{'{0, 0, 0}, '{ONE, 0, 0}, '{0, 0, ONE}, '{0, 0, 0}});
    send_tri('{'{MAXV, MAXV, MAXV}, '{MINV, MINV, MINV}, '{MAXV, MINV, MAXV},
               '{MAXV, MAXV, MAXV}});
    send_tri('{'{MINV, MINV, MINV}, '{MAXV, MINV, MAXV}, '{MINV, MAXV, MINV},
               '{MINV, MINV, MINV}});
    send_tri('{'{-ONE, -ONE, 0}, '{3 * ONE, -ONE, 0}, '{-ONE, 3 * ONE, 0}, '{0, 0, 0}});
    send_tri('{'{0, 0, 100 * ONE}, '{ONE, 0, 100 * ONE}, '{0, ONE, 100 * ONE},
               '{0, 0, 0}});
    send_tri('{'{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, 0}, '{0, 0, 0}});
    drain();

    // Supplied normal mode, zero tolerance, ray from behind.
    set_ray('{ONE / 4, ONE / 4, -3 * ONE}, '{0, 0, ONE}, 1'b0, 16'd0);
    send_tri('{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}});
    send_tri('{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, 0}});
    send_tri('{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{MAXV, MINV, MINV}});
    send_tri('{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{ONE, 0, 0}});
    drain();

    // Extreme ray, full tolerance.
    set_ray('{MAXV, MINV, MAXV}, '{MINV, MAXV, ONE}, 1'b1, 16'hffff);
    send_tri('{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, 0}});
    send_tri('{'{MINV, 0, MAXV}, '{0, MAXV, 0}, '{MAXV, MINV, 0}, '{0, 0, 0}});
    drain();

    // Random phases, each with its own ray.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_ray(near_vec(ONE), '{0, 0, ONE}, 1'b1, 16'd655);
        1: set_ray(near_vec(ONE), near_vec(2 * ONE), 1'b1, 16'($urandom));
        2: set_ray(near_vec(ONE), near_vec(2 * ONE), 1'b0, 16'd0);
        3: set_ray(wild_vec(), wild_vec(), 1'b1, 16'hffff);
        4: set_ray(near_vec(ONE), '{0, 0, 0}, 1'($urandom), 16'($urandom));
        default: set_ray(near_vec(ONE), near_vec(ONE), 1'b1, 16'($urandom));
      endcase
      for (int n = 0; n < 250; ) begin
        burst = $urandom_range(0, 3) == 0 ? 20 : $urandom_range(1, 8);
        for (int j = 0; j < burst; j++) begin
          t = random_tri();
          send_tri(t);
          n++;
        end
        if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 6));
        if (n == 125 && ph == 2) drain();
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
